FILE: rtl/psgms_pkg.sv
// Shared types, codes and the microcode table of the music sequencer.
package psgms_pkg;

   // Default sizes for the top-level parameters.
   localparam int SONG_DEPTH_DEF = 256;
   localparam int MAX_NOTES_DEF  = 16;

   // Item commands carried in the input tuser.
   localparam logic [2:0] CMD_LOAD  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_TICK  = 3'd3;
   localparam logic [2:0] CMD_DECAY = 3'd4;

   // Register indexes on the csr port.
   localparam logic [2:0] CFG_END   = 3'd0;
   localparam logic [2:0] CFG_LOOP  = 3'd1;
   localparam logic [2:0] CFG_OFF   = 3'd2;
   localparam logic [2:0] CFG_TEMPO = 3'd3;
   localparam logic [2:0] CFG_DECAY = 3'd4;

   // Register reset values.
   localparam logic [7:0] END_RESET   = 8'hff;
   localparam logic [7:0] LOOP_RESET  = 8'hfe;
   localparam logic [3:0] OFF_RESET   = 4'hf;
   localparam logic [7:0] TEMPO_RESET = 8'd3;
   localparam logic [7:0] DECAY_RESET = 8'd0;

   // Sound chip byte fields.
   localparam logic [7:0] DECAY_BASE    = 8'h90;
   localparam logic [3:0] VOL_MAX       = 4'hf;
   localparam logic [1:0] CH_UNRECORDED = 2'd3;
   localparam logic [1:0] CH_LAST       = 2'd3;

   // Datapath operations, one per microcode step.
   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_START,
      OP_STOP,
      OP_TEMPO_DEC,
      OP_TEMPO_RELOAD,
      OP_NOTES_CLR,
      OP_WAIT_DEC,
      OP_LATCH,
      OP_BUF_CMD,
      OP_BUF_B2,
      OP_BUF_VOL,
      OP_RESTART,
      OP_SET_WAIT,
      OP_DCH_CLR,
      OP_DECAY_CH,
      OP_DECAY_RELOAD,
      OP_DECAY_DEC,
      OP_POST
   } op_type;

   // Branch conditions of the step counter.
   typedef enum logic [3:0] {
      C_NEXT,
      C_ALWAYS,
      C_DISPATCH,
      C_TEMPO_NZ,
      C_NOT_PLAY,
      C_WAIT_NZ,
      C_CAP,
      C_IS_END,
      C_IS_LOOP,
      C_IS_WAITB,
      C_DECAY_NZ,
      C_DCH_MORE,
      C_DRAIN_IDLE
   } cond_type;

   localparam int STEP_W = 5;
   typedef logic [STEP_W-1:0] step_type;

   // Step addresses of the program.
   localparam step_type ST_IDLE   = 5'd0;
   localparam step_type ST_LOAD   = 5'd1;
   localparam step_type ST_START  = 5'd2;
   localparam step_type ST_STOP   = 5'd3;
   localparam step_type ST_TICK   = 5'd4;
   localparam step_type ST_TREL   = 5'd5;
   localparam step_type ST_TWCHK  = 5'd6;
   localparam step_type ST_TOP    = 5'd7;
   localparam step_type ST_RD     = 5'd8;
   localparam step_type ST_ENDCHK = 5'd9;
   localparam step_type ST_LPCHK  = 5'd10;
   localparam step_type ST_CLASS  = 5'd11;
   localparam step_type ST_NCMD   = 5'd12;
   localparam step_type ST_NB2    = 5'd13;
   localparam step_type ST_NVOL   = 5'd14;
   localparam step_type ST_TEND   = 5'd15;
   localparam step_type ST_TLOOP  = 5'd16;
   localparam step_type ST_LRD    = 5'd17;
   localparam step_type ST_LLAT   = 5'd18;
   localparam step_type ST_SETW   = 5'd19;
   localparam step_type ST_TDEC   = 5'd20;
   localparam step_type ST_WDEC   = 5'd21;
   localparam step_type ST_DECAY  = 5'd22;
   localparam step_type ST_DCLR   = 5'd23;
   localparam step_type ST_DLOOP  = 5'd24;
   localparam step_type ST_DREL   = 5'd25;
   localparam step_type ST_DDEC   = 5'd26;
   localparam step_type ST_FIN    = 5'd27;
   localparam step_type ST_FWAIT  = 5'd28;
   localparam step_type ST_FSPIN  = 5'd29;

   // One control word.
   typedef struct packed {
      op_type   op;
      logic     rd;
      cond_type cond;
      step_type target;
   } uword_type;

   // Control handed from the sequencer to the datapath.
   typedef struct packed {
      op_type op;
      logic   rd;
   } ctrl_type;

   // Status flags returned by the datapath for branching.
   typedef struct packed {
      logic tempo_nz;
      logic play;
      logic wait_nz;
      logic cap;
      logic is_end;
      logic is_loop;
      logic is_waitb;
      logic decay_nz;
      logic dch_more;
   } stat_type;

   function automatic uword_type uw(input op_type op, input logic rd,
                                    input cond_type cond, input step_type target);
      uword_type w;
      w.op     = op;
      w.rd     = rd;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   // The microprogram.
   function automatic uword_type ucode(input step_type s);
      uword_type w;
      case (s)
         ST_IDLE:   w = uw(OP_NOP,          1'b0, C_DISPATCH,   ST_IDLE);
         ST_LOAD:   w = uw(OP_LOAD,         1'b0, C_ALWAYS,     ST_IDLE);
         ST_START:  w = uw(OP_START,        1'b0, C_ALWAYS,     ST_IDLE);
         ST_STOP:   w = uw(OP_STOP,         1'b0, C_ALWAYS,     ST_IDLE);
         ST_TICK:   w = uw(OP_NOP,          1'b0, C_TEMPO_NZ,   ST_TDEC);
         ST_TREL:   w = uw(OP_TEMPO_RELOAD, 1'b0, C_NOT_PLAY,   ST_FIN);
         ST_TWCHK:  w = uw(OP_NOTES_CLR,    1'b0, C_WAIT_NZ,    ST_WDEC);
         ST_TOP:    w = uw(OP_NOP,          1'b0, C_CAP,        ST_FIN);
         ST_RD:     w = uw(OP_NOP,          1'b1, C_NEXT,       ST_IDLE);
         ST_ENDCHK: w = uw(OP_LATCH,        1'b0, C_IS_END,     ST_TEND);
         ST_LPCHK:  w = uw(OP_NOP,          1'b0, C_IS_LOOP,    ST_TLOOP);
         ST_CLASS:  w = uw(OP_NOP,          1'b0, C_IS_WAITB,   ST_SETW);
         ST_NCMD:   w = uw(OP_BUF_CMD,      1'b1, C_NEXT,       ST_IDLE);
         ST_NB2:    w = uw(OP_BUF_B2,       1'b1, C_NEXT,       ST_IDLE);
         ST_NVOL:   w = uw(OP_BUF_VOL,      1'b0, C_ALWAYS,     ST_TOP);
         ST_TEND:   w = uw(OP_STOP,         1'b0, C_ALWAYS,     ST_FIN);
         ST_TLOOP:  w = uw(OP_RESTART,      1'b0, C_NEXT,       ST_IDLE);
         ST_LRD:    w = uw(OP_NOP,          1'b1, C_NEXT,       ST_IDLE);
         ST_LLAT:   w = uw(OP_LATCH,        1'b0, C_ALWAYS,     ST_CLASS);
         ST_SETW:   w = uw(OP_SET_WAIT,     1'b0, C_ALWAYS,     ST_FIN);
         ST_TDEC:   w = uw(OP_TEMPO_DEC,    1'b0, C_ALWAYS,     ST_FIN);
         ST_WDEC:   w = uw(OP_WAIT_DEC,     1'b0, C_ALWAYS,     ST_FIN);
         ST_DECAY:  w = uw(OP_NOP,          1'b0, C_DECAY_NZ,   ST_DDEC);
         ST_DCLR:   w = uw(OP_DCH_CLR,      1'b0, C_NEXT,       ST_IDLE);
         ST_DLOOP:  w = uw(OP_DECAY_CH,     1'b0, C_DCH_MORE,   ST_DLOOP);
         ST_DREL:   w = uw(OP_DECAY_RELOAD, 1'b0, C_ALWAYS,     ST_FIN);
         ST_DDEC:   w = uw(OP_DECAY_DEC,    1'b0, C_ALWAYS,     ST_FIN);
         ST_FIN:    w = uw(OP_POST,         1'b0, C_NEXT,       ST_IDLE);
         ST_FWAIT:  w = uw(OP_NOP,          1'b0, C_DRAIN_IDLE, ST_IDLE);
         ST_FSPIN:  w = uw(OP_NOP,          1'b0, C_ALWAYS,     ST_FWAIT);
         default:   w = uw(OP_NOP,          1'b0, C_ALWAYS,     ST_IDLE);
      endcase
      return w;
   endfunction

   // Entry step for each item command; unknown commands finish at once.
   function automatic step_type dispatch(input logic [2:0] command);
      step_type s;
      case (command)
         CMD_LOAD:  s = ST_LOAD;
         CMD_START: s = ST_START;
         CMD_STOP:  s = ST_STOP;
         CMD_TICK:  s = ST_TICK;
         CMD_DECAY: s = ST_DECAY;
         default:   s = ST_IDLE;
      endcase
      return s;
   endfunction

endpackage

FILE: rtl/psgms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psgms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/psgms_sequencer.sv
// Step counter and microcode fetch that steer the sequencer datapath.
module psgms_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic [2:0]           req_command,
   output logic                 req_tready,
   output logic                 accept,
   input  psgms_pkg::stat_type  stat,
   input  logic                 drain_busy,
   output psgms_pkg::ctrl_type  ctrl
);

   psgms_pkg::step_type  step_ff;
   psgms_pkg::step_type  step_in;
   psgms_pkg::uword_type word;
   logic                 take;

   // Fetch the control word of the current step.
   assign word       = psgms_pkg::ucode(step_ff);
   assign req_tready = (step_ff == psgms_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign ctrl.op    = word.op;
   assign ctrl.rd    = word.rd;

   // Evaluate the branch condition of the word.
   always_comb begin
      case (word.cond)
         psgms_pkg::C_NEXT:       take = 1'b0;
         psgms_pkg::C_ALWAYS:     take = 1'b1;
         psgms_pkg::C_TEMPO_NZ:   take = stat.tempo_nz;
         psgms_pkg::C_NOT_PLAY:   take = !stat.play;
         psgms_pkg::C_WAIT_NZ:    take = stat.wait_nz;
         psgms_pkg::C_CAP:        take = stat.cap;
         psgms_pkg::C_IS_END:     take = stat.is_end;
         psgms_pkg::C_IS_LOOP:    take = stat.is_loop;
         psgms_pkg::C_IS_WAITB:   take = stat.is_waitb;
         psgms_pkg::C_DECAY_NZ:   take = stat.decay_nz;
         psgms_pkg::C_DCH_MORE:   take = stat.dch_more;
         psgms_pkg::C_DRAIN_IDLE: take = !drain_busy;
         default:                 take = 1'b0;
      endcase
   end

   // Next step: dispatch on a new beat, jump, or fall through.
   always_comb begin
      if (word.cond == psgms_pkg::C_DISPATCH) begin
         step_in = accept ? psgms_pkg::dispatch(req_command) : psgms_pkg::ST_IDLE;
      end else if (take) begin
         step_in = word.target;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= psgms_pkg::ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

FILE: rtl/psgms_datapath.sv
// Sequencer registers, configuration, song access and result buffer writes.
module psgms_datapath #(
   parameter int SONG_DEPTH         = psgms_pkg::SONG_DEPTH_DEF,
   parameter int MAX_NOTES_PER_TICK = psgms_pkg::MAX_NOTES_DEF,
   parameter int BUF_DEPTH          = 3 * psgms_pkg::MAX_NOTES_DEF + 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [7:0]                        req_address,
   input  logic [7:0]                        req_data_byte,
   input  logic                              csr_wen,
   input  logic [2:0]                        csr_index,
   input  logic [7:0]                        csr_wdata,
   input  psgms_pkg::ctrl_type               ctrl,
   output psgms_pkg::stat_type               stat,
   output logic                              song_wen,
   output logic [$clog2(SONG_DEPTH)-1:0]     song_waddr,
   output logic [7:0]                        song_wdata,
   output logic [$clog2(SONG_DEPTH)-1:0]     song_raddr,
   input  logic [7:0]                        song_rdata,
   output logic                              buf_wen,
   output logic [$clog2(BUF_DEPTH)-1:0]      buf_waddr,
   output logic [7:0]                        buf_wdata,
   output logic                              post_valid,
   output logic [$clog2(BUF_DEPTH+1)-1:0]    post_count,
   output logic                              post_playing
);

   localparam int SONG_AW = $clog2(SONG_DEPTH);
   localparam int BUF_AW  = $clog2(BUF_DEPTH);
   localparam int CNT_W   = $clog2(BUF_DEPTH + 1);
   localparam int NOTES_W = $clog2(MAX_NOTES_PER_TICK + 1);

   // Configuration registers.
   logic [7:0] cfg_end_ff;
   logic [7:0] cfg_loop_ff;
   logic [3:0] cfg_off_ff;
   logic [7:0] cfg_tempo_ff;
   logic [7:0] cfg_decay_ff;

   // Item fields and player state.
   logic [7:0]         addr_ff;
   logic [7:0]         data_ff;
   logic [7:0]         cmd_ff;
   logic [7:0]         ptr_ff;
   logic [7:0]         start_ff;
   logic [7:0]         tempo_ff;
   logic [6:0]         wait_ff;
   logic               play_ff;
   logic [3:0]         vol_ff [4];
   logic [7:0]         decay_ff;
   logic [NOTES_W-1:0] notes_ff;
   logic [CNT_W-1:0]   nbuf_ff;
   logic [1:0]         dch_ff;

   logic [SONG_AW-1:0] song_idx_lut [256];
   logic [3:0]         dvol_old;
   logic [3:0]         dvol_new;
   logic [1:0]         note_ch;

   // Song address folding: address modulo the song depth, as a constant table.
   for (genvar g = 0; g < 256; g++) begin : g_idx
      assign song_idx_lut[g] = SONG_AW'(g % SONG_DEPTH);
   end

   // Song memory access.
   assign song_wen   = (ctrl.op == psgms_pkg::OP_LOAD);
   assign song_waddr = song_idx_lut[addr_ff];
   assign song_wdata = data_ff;
   assign song_raddr = song_idx_lut[ptr_ff];

   // Volume step of the decay loop.
   assign dvol_old = vol_ff[dch_ff];
   assign dvol_new = (dvol_old < psgms_pkg::VOL_MAX) ? dvol_old + 4'd1 : dvol_old;
   assign note_ch  = song_rdata[6:5];

   // Result buffer writes.
   always_comb begin
      buf_wen   = 1'b0;
      buf_wdata = song_rdata;
      case (ctrl.op)
         psgms_pkg::OP_BUF_CMD: begin
            buf_wen   = 1'b1;
            buf_wdata = cmd_ff;
         end
         psgms_pkg::OP_BUF_B2,
         psgms_pkg::OP_BUF_VOL: begin
            buf_wen   = 1'b1;
         end
         psgms_pkg::OP_DECAY_CH: begin
            buf_wen   = 1'b1;
            buf_wdata = psgms_pkg::DECAY_BASE | {1'b0, dch_ff, 5'd0} | {4'd0, dvol_new};
         end
         default: begin
            buf_wen   = 1'b0;
         end
      endcase
   end
   assign buf_waddr = nbuf_ff[BUF_AW-1:0];

   // Hand the finished result count to the output stage.
   assign post_valid   = (ctrl.op == psgms_pkg::OP_POST) && (nbuf_ff != '0);
   assign post_count   = nbuf_ff;
   assign post_playing = play_ff;

   // Branch status.
   assign stat.tempo_nz = (tempo_ff != 8'd0);
   assign stat.play     = play_ff;
   assign stat.wait_nz  = (wait_ff != 7'd0);
   assign stat.cap      = (notes_ff == NOTES_W'(MAX_NOTES_PER_TICK));
   assign stat.is_end   = (song_rdata == cfg_end_ff);
   assign stat.is_loop  = (cmd_ff == cfg_loop_ff);
   assign stat.is_waitb = !cmd_ff[7];
   assign stat.decay_nz = (decay_ff != 8'd0);
   assign stat.dch_more = (dch_ff != psgms_pkg::CH_LAST);

   // Item latch, carries no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff <= req_address;
         data_ff <= req_data_byte;
      end
      if (ctrl.op == psgms_pkg::OP_LATCH) begin
         cmd_ff <= song_rdata;
      end
   end

   // Configuration writes and the operations of each step.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_end_ff   <= psgms_pkg::END_RESET;
         cfg_loop_ff  <= psgms_pkg::LOOP_RESET;
         cfg_off_ff   <= psgms_pkg::OFF_RESET;
         cfg_tempo_ff <= psgms_pkg::TEMPO_RESET;
         cfg_decay_ff <= psgms_pkg::DECAY_RESET;
         ptr_ff       <= 8'd0;
         start_ff     <= 8'd0;
         tempo_ff     <= 8'd0;
         wait_ff      <= 7'd0;
         play_ff      <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            vol_ff[i] <= 4'd0;
         end
         decay_ff     <= 8'd0;
         notes_ff     <= '0;
         nbuf_ff      <= '0;
         dch_ff       <= 2'd0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               psgms_pkg::CFG_END:   cfg_end_ff   <= csr_wdata;
               psgms_pkg::CFG_LOOP:  cfg_loop_ff  <= csr_wdata;
               psgms_pkg::CFG_OFF:   cfg_off_ff   <= csr_wdata[3:0];
               psgms_pkg::CFG_TEMPO: cfg_tempo_ff <= csr_wdata;
               psgms_pkg::CFG_DECAY: cfg_decay_ff <= csr_wdata;
               default: begin
               end
            endcase
         end

         // Each song read advances the pointer.
         if (ctrl.rd) begin
            ptr_ff <= ptr_ff + 8'd1;
         end

         case (ctrl.op)
            psgms_pkg::OP_START,
            psgms_pkg::OP_RESTART: begin
               if (ctrl.op == psgms_pkg::OP_START) begin
                  start_ff <= addr_ff;
                  ptr_ff   <= addr_ff;
               end else begin
                  ptr_ff   <= start_ff;
               end
               tempo_ff <= cfg_tempo_ff;
               decay_ff <= cfg_decay_ff;
               play_ff  <= 1'b1;
               for (int i = 0; i < 4; i++) begin
                  vol_ff[i] <= cfg_off_ff;
               end
            end
            psgms_pkg::OP_STOP:         play_ff  <= 1'b0;
            psgms_pkg::OP_TEMPO_DEC:    tempo_ff <= tempo_ff - 8'd1;
            psgms_pkg::OP_TEMPO_RELOAD: tempo_ff <= cfg_tempo_ff;
            psgms_pkg::OP_NOTES_CLR:    notes_ff <= '0;
            psgms_pkg::OP_WAIT_DEC:     wait_ff  <= wait_ff - 7'd1;
            psgms_pkg::OP_SET_WAIT: begin
               wait_ff <= (cmd_ff[6:0] != 7'd0) ? cmd_ff[6:0] - 7'd1 : 7'd0;
            end
            psgms_pkg::OP_BUF_CMD,
            psgms_pkg::OP_BUF_B2: begin
               nbuf_ff <= nbuf_ff + 1'b1;
            end
            psgms_pkg::OP_BUF_VOL: begin
               nbuf_ff  <= nbuf_ff + 1'b1;
               notes_ff <= notes_ff + 1'b1;
               // The fourth channel's volume is not tracked.
               if (note_ch != psgms_pkg::CH_UNRECORDED) begin
                  vol_ff[note_ch] <= song_rdata[3:0];
               end
            end
            psgms_pkg::OP_DCH_CLR:      dch_ff   <= 2'd0;
            psgms_pkg::OP_DECAY_CH: begin
               vol_ff[dch_ff] <= dvol_new;
               nbuf_ff        <= nbuf_ff + 1'b1;
               dch_ff         <= dch_ff + 2'd1;
            end
            psgms_pkg::OP_DECAY_RELOAD: decay_ff <= cfg_decay_ff;
            psgms_pkg::OP_DECAY_DEC:    decay_ff <= decay_ff - 8'd1;
            psgms_pkg::OP_POST:         nbuf_ff  <= '0;
            default: begin
            end
         endcase
      end
   end

endmodule

FILE: rtl/psgms_drain.sv
// Output stage that streams buffered chip bytes with last and playing marks.
module psgms_drain #(
   parameter int BUF_DEPTH = 3 * psgms_pkg::MAX_NOTES_DEF + 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           post_valid,
   input  logic [$clog2(BUF_DEPTH+1)-1:0] post_count,
   input  logic                           post_playing,
   output logic [$clog2(BUF_DEPTH)-1:0]   buf_raddr,
   input  logic [7:0]                     buf_rdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,
   output logic                           rsp_tlast,
   output logic [0:0]                     rsp_tuser,
   output logic                           busy
);

   localparam int BUF_AW = $clog2(BUF_DEPTH);
   localparam int CNT_W  = $clog2(BUF_DEPTH + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] rd_idx_ff;
   logic             inflight_ff;
   logic             infl_last_ff;
   logic             play_ff;
   logic             out_valid_ff;
   logic [7:0]       out_data_ff;
   logic             out_last_ff;
   logic             issue;

   // Start a buffer read only when its data will find the output register free.
   assign issue = busy_ff && (rd_idx_ff != cnt_ff) && !inflight_ff &&
                  (!out_valid_ff || rsp_tready);
   assign buf_raddr = rd_idx_ff[BUF_AW-1:0];

   // Control of the drain.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         inflight_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (post_valid) begin
            busy_ff   <= 1'b1;
            rd_idx_ff <= '0;
         end
         if (issue) begin
            rd_idx_ff   <= rd_idx_ff + 1'b1;
            inflight_ff <= 1'b1;
         end
         if (inflight_ff) begin
            inflight_ff  <= 1'b0;
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && rsp_tready) begin
            out_valid_ff <= 1'b0;
            if (out_last_ff) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (post_valid) begin
         cnt_ff  <= post_count;
         play_ff <= post_playing;
      end
      if (issue) begin
         infl_last_ff <= (CNT_W'(rd_idx_ff + 1'b1) == cnt_ff);
      end
      if (inflight_ff) begin
         out_data_ff <= buf_rdata;
         out_last_ff <= infl_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = play_ff;
   assign busy       = busy_ff;

endmodule

FILE: rtl/psg_music_sequencer_top.sv
// Top level of the music sequencer for a four-channel sound chip.
// Music sequencer: load beats fill the song memory, start and stop beats control play, tick
// beats advance the tempo prescaler and read song bytes, and decay beats fade all four channel
// volumes. A microcoded step counter drives a small datapath that reads the song memory at most
// one byte per step; chip bytes an item produces are collected in a result buffer and then
// streamed out, with tlast on the final byte and tuser[0] giving the play flag after the item.
// A new beat is taken only once all results of the previous one are delivered. A tick reads
// its notes through the single read port of the song memory, and a decay step that fades
// writes four results, one per channel. Song memory contents are undefined after reset until
// loaded.
module psg_music_sequencer_top #(
   parameter int SONG_DEPTH         = psgms_pkg::SONG_DEPTH_DEF,
   parameter int MAX_NOTES_PER_TICK = psgms_pkg::MAX_NOTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // address [7:0], data_byte [15:8]
   input  logic [2:0]  req_tuser,   // command [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // chip_byte [7:0]
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser,   // playing [0]
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int BUF_DEPTH = 3 * MAX_NOTES_PER_TICK + 4;
   localparam int SONG_AW   = $clog2(SONG_DEPTH);
   localparam int BUF_AW    = $clog2(BUF_DEPTH);
   localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

   psgms_pkg::ctrl_type ctrl;
   psgms_pkg::stat_type stat;
   logic                accept;
   logic                drain_busy;
   logic                song_wen;
   logic [SONG_AW-1:0]  song_waddr;
   logic [7:0]          song_wdata;
   logic [SONG_AW-1:0]  song_raddr;
   logic [7:0]          song_rdata;
   logic                buf_wen;
   logic [BUF_AW-1:0]   buf_waddr;
   logic [7:0]          buf_wdata;
   logic [BUF_AW-1:0]   buf_raddr;
   logic [7:0]          buf_rdata;
   logic                post_valid;
   logic [CNT_W-1:0]    post_count;
   logic                post_playing;

   // Microcode step counter.
   psgms_sequencer u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_command (req_tuser),
      .req_tready  (req_tready),
      .accept      (accept),
      .stat        (stat),
      .drain_busy  (drain_busy),
      .ctrl        (ctrl)
   );

   // Player registers and configuration.
   psgms_datapath #(
      .SONG_DEPTH         (SONG_DEPTH),
      .MAX_NOTES_PER_TICK (MAX_NOTES_PER_TICK),
      .BUF_DEPTH          (BUF_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_address   (req_tdata[7:0]),
      .req_data_byte (req_tdata[15:8]),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .ctrl          (ctrl),
      .stat          (stat),
      .song_wen      (song_wen),
      .song_waddr    (song_waddr),
      .song_wdata    (song_wdata),
      .song_raddr    (song_raddr),
      .song_rdata    (song_rdata),
      .buf_wen       (buf_wen),
      .buf_waddr     (buf_waddr),
      .buf_wdata     (buf_wdata),
      .post_valid    (post_valid),
      .post_count    (post_count),
      .post_playing  (post_playing)
   );

   // Song memory.
   psgms_ram #(
      .WIDTH (8),
      .DEPTH (SONG_DEPTH)
   ) u_song_ram (
      .clock   (clock),
      .wr_en   (song_wen),
      .wr_addr (song_waddr),
      .wr_data (song_wdata),
      .rd_addr (song_raddr),
      .rd_data (song_rdata)
   );

   // Result buffer.
   psgms_ram #(
      .WIDTH (8),
      .DEPTH (BUF_DEPTH)
   ) u_buf_ram (
      .clock   (clock),
      .wr_en   (buf_wen),
      .wr_addr (buf_waddr),
      .wr_data (buf_wdata),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

   // Output stream.
   psgms_drain #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_drain (
      .clock        (clock),
      .reset        (reset),
      .post_valid   (post_valid),
      .post_count   (post_count),
      .post_playing (post_playing),
      .buf_raddr    (buf_raddr),
      .buf_rdata    (buf_rdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser),
      .busy         (drain_busy)
   );

   // No new item is taken while results are still pending.
   a_no_accept_while_results: assert property (
      @(posedge clock) disable iff (reset) rsp_tvalid |-> !req_tready
   ) else $error("item accepted while results pending");

   // An accepted item of a known command holds ready low in the cycle after it is taken;
   // unknown commands are dropped on the spot.
   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
         (req_tvalid && req_tready && (req_tuser <= psgms_pkg::CMD_DECAY)) |=> !req_tready
   ) else $error("ready stayed high after an accepted item");

   // Nothing follows the final byte of an item.
   a_quiet_after_last: assert property (
      @(posedge clock) disable iff (reset)
         (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid
   ) else $error("result beat after the final byte");

   // The result buffer is never written while it is being streamed out.
   a_no_write_during_drain: assert property (
      @(posedge clock) disable iff (reset) drain_busy |-> !buf_wen
   ) else $error("result buffer written during drain");

endmodule
